// ===== rtl/chs_pkg.sv =====
package chs_pkg;

    localparam int XW              = 36;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int GUARD_SHIFT     = 16;

    localparam logic [15:0] DECL_RESET  = 16'd2079;
    localparam logic [15:0] SECTOR_BIAS = 16'd2048;
    localparam logic [31:0] ACC_HALF    = 32'h8000_0000;
    localparam logic [31:0] ROUND_BIAS  = 32'h0000_8000;

    // atan(2^-i) in 32-bit binary angle units
    localparam logic [31:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          acc;
    } t_cordic_beat;

endpackage

// ===== rtl/chs_cordic_stage.sv =====
module chs_cordic_stage
    import chs_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_cordic_beat i_beat,
    output logic         o_valid,
    output t_cordic_beat o_beat
);

    logic                 r_valid;
    t_cordic_beat         r_beat;
    t_cordic_beat         n_beat;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 y_pos;

    assign dx    = i_beat.y >>> STAGE;
    assign dy    = i_beat.x >>> STAGE;
    assign y_pos = !i_beat.y[XW-1] && (i_beat.y != '0);

    always_comb begin
        n_beat      = i_beat;
        if (y_pos) begin
            n_beat.x   = i_beat.x + dx;
            n_beat.y   = i_beat.y - dy;
            n_beat.acc = i_beat.acc + ATAN_TABLE[STAGE];
        end else begin
            n_beat.x   = i_beat.x - dx;
            n_beat.y   = i_beat.y + dy;
            n_beat.acc = i_beat.acc - ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== rtl/compass_heading_sector_core.sv =====
// registers: pre-rotation, one per cordic stage, angle, output
// throughput: one beat per cycle when not stalled; one cordic micro-rotation per stage
// the whole pipeline holds while the output beat is stalled
// reset (synchronous, active low) clears all valid bits and loads declination 2079
module compass_heading_sector_core
    import chs_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_field_x,
    input  logic [15:0] i_field_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_heading,
    output logic [3:0]  o_sector
);

    localparam int NSTAGE = (CORDIC_ITERATIONS < ANGLE_TABLE_LEN) ?
                            CORDIC_ITERATIONS : ANGLE_TABLE_LEN;

    logic         advance;
    logic [15:0]  r_declination;

    logic                 x_neg;
    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;
    t_cordic_beat         n_pre;

    logic         pipe_valid [NSTAGE+1];
    t_cordic_beat pipe_beat  [NSTAGE+1];

    logic         r_pre_valid;
    t_cordic_beat r_pre;

    logic [31:0]  round_sum;
    logic [15:0]  n_angle;
    logic         r_angle_valid;
    logic [15:0]  r_angle;

    logic [15:0]  n_heading;
    logic [15:0]  sector_sum;
    logic         r_out_valid;
    logic [15:0]  r_heading;
    logic [3:0]   r_sector;

    assign advance = !(r_out_valid && i_stall);
    assign o_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declination <= DECL_RESET;
        end else if (i_cfg_we) begin
            r_declination <= i_cfg_wdata;
        end
    end

    // pre-rotation into the right half plane, scaled by 2^16
    assign x_ext = XW'($signed(i_field_x));
    assign y_ext = XW'($signed(i_field_y));
    assign x_neg = i_field_x[15];

    always_comb begin
        n_pre.zero = (i_field_x == '0) && (i_field_y == '0);
        if (x_neg) begin
            n_pre.x   = (-x_ext) <<< GUARD_SHIFT;
            n_pre.y   = (-y_ext) <<< GUARD_SHIFT;
            n_pre.acc = ACC_HALF;
        end else begin
            n_pre.x   = x_ext <<< GUARD_SHIFT;
            n_pre.y   = y_ext <<< GUARD_SHIFT;
            n_pre.acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (advance) begin
            r_pre_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pre <= n_pre;
        end
    end

    assign pipe_valid[0] = r_pre_valid;
    assign pipe_beat[0]  = r_pre;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        chs_cordic_stage #(
            .STAGE(g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (pipe_valid[g]),
            .i_beat  (pipe_beat[g]),
            .o_valid (pipe_valid[g+1]),
            .o_beat  (pipe_beat[g+1])
        );
    end

    // round to 16-bit angle, zero vector gives angle 0
    assign round_sum = pipe_beat[NSTAGE].acc + ROUND_BIAS;
    assign n_angle   = pipe_beat[NSTAGE].zero ? 16'd0 : round_sum[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_valid <= 1'b0;
        end else if (advance) begin
            r_angle_valid <= pipe_valid[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_angle <= n_angle;
        end
    end

    assign n_heading  = r_angle + r_declination;
    assign sector_sum = n_heading + SECTOR_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_angle_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_heading <= n_heading;
            r_sector  <= sector_sum[15:12];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_heading = r_heading;
    assign o_sector  = r_sector;

endmodule

// ===== rtl/chs_checker.sv =====
module chs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_heading,
    input logic [3:0]  o_sector
);

    logic [15:0] sector_sum;

    assign sector_sum = o_heading + 16'd2048;

    // output beat held under stall
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_heading) && $stable(o_sector))
        else $error("output beat changed while stalled");

    // sector matches heading on every valid output beat
    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sector == sector_sum[15:12])
        else $error("sector does not match heading");

    // input side only stalls when the output beat is stuck
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && i_stall) |-> !o_stall)
        else $error("input stalled with free output");

    a_reset_clear: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid)
        else $error("output valid after reset");

endmodule

bind compass_heading_sector_core chs_checker u_chs_checker (.*);

// ===== tb/compass_heading_sector_core_tb.sv =====
module compass_heading_sector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MICRO_ROTATIONS = 16;
    localparam int PIPE_LATENCY    = MICRO_ROTATIONS + 3;
    localparam int BEATS_PER_SET   = 180;
    localparam int IDLE_PCT        = 30;

    localparam logic [31:0] ARCTAN_BAM [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic [15:0] fx;
        logic [15:0] fy;
    } t_mag_sample;

    typedef struct {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] heading;
        logic [3:0]  sector;
    } t_bearing;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        i_valid     = 1'b0;
    logic [15:0] i_field_x   = 16'd0;
    logic [15:0] i_field_y   = 16'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_heading;
    logic [3:0]  o_sector;

    t_mag_sample sample_q [$];
    t_bearing    bearing_q [$];
    logic [15:0] decl_model = 16'd2079;
    logic        calm       = 1'b0;
    int          n_queued   = 0;
    int          n_in       = 0;
    int          n_out      = 0;
    int          n_bad      = 0;
    int          n_cfg      = 0;

    compass_heading_sector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_field_x   (i_field_x),
        .i_field_y   (i_field_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_heading   (o_heading),
        .o_sector    (o_sector)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // vectoring cordic, binary angle with 2^32 per circle, rounded to 16 bits
    function automatic logic [15:0] bearing_angle(logic signed [15:0] fx,
                                                  logic signed [15:0] fy);
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        if (fx == 16'sd0 && fy == 16'sd0) begin
            return 16'd0;
        end
        x = fx;
        y = fy;
        acc = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < MICRO_ROTATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                acc = acc + ARCTAN_BAM[i];
            end else begin
                x = x - dx;
                y = y + dy;
                acc = acc - ARCTAN_BAM[i];
            end
        end
        acc = acc + 32'h0000_8000;
        return acc[31:16];
    endfunction

    function automatic logic [15:0] raw_axis();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2: return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(logic [15:0] fx, logic [15:0] fy);
        t_mag_sample s;
        s.fx = fx;
        s.fy = fy;
        sample_q.push_back(s);
        n_queued++;
    endtask

    task automatic set_declination(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        decl_model = v;
        n_cfg++;
    endtask

    task automatic drain_headings();
        while (n_in != n_queued || bearing_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        t_mag_sample s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s = sample_q.pop_front();
                i_valid <= 1'b1;
                i_field_x <= s.fx;
                i_field_y <= s.fy;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !calm) begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // predict on accepted sample beats, check heading beats in order
    always @(posedge i_clk) begin
        t_bearing    want;
        logic [15:0] biased;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want.fx = i_field_x;
                want.fy = i_field_y;
                want.heading = bearing_angle(i_field_x, i_field_y) + decl_model;
                biased = want.heading + 16'd2048;
                want.sector = biased[15:12];
                bearing_q.push_back(want);
                n_in++;
            end
            if (o_valid && !i_stall) begin
                if (bearing_q.size() == 0) begin
                    $display("%0t: unexpected beat heading %h sector %0d",
                             $time, o_heading, o_sector);
                    n_bad++;
                end else begin
                    want = bearing_q.pop_front();
                    if (o_heading !== want.heading) begin
                        $display("%0t: heading x=%h y=%h expected %h actual %h",
                                 $time, want.fx, want.fy, want.heading, o_heading);
                        n_bad++;
                    end
                    if (o_sector !== want.sector) begin
                        $display("%0t: sector x=%h y=%h expected %0d actual %0d",
                                 $time, want.fx, want.fy, want.sector, o_sector);
                        n_bad++;
                    end
                    n_out++;
                end
            end
        end
    end

    initial begin
        logic [15:0] decl_set [$];
        decl_set = '{16'd2079, 16'h0800, 16'hF800, 16'h7FFF, 16'h8000,
                     16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom),
                     16'($urandom)};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < decl_set.size(); p++) begin
            if (p != 0) begin
                set_declination(decl_set[p]);
            end
            calm = (p == 4);
            if (p == 0) begin
                push_sample(16'h0000, 16'h0000);
                push_sample(16'h7FFF, 16'h0000);
                push_sample(16'h8000, 16'h0000);
                push_sample(16'h0000, 16'h7FFF);
                push_sample(16'h0000, 16'h8000);
                push_sample(16'h7FFF, 16'h7FFF);
                push_sample(16'h8000, 16'h8000);
                push_sample(16'h7FFF, 16'h8000);
                push_sample(16'h8000, 16'h7FFF);
                push_sample(16'h0001, 16'h0000);
                push_sample(16'hFFFF, 16'h0000);
                push_sample(16'h0000, 16'h0001);
                push_sample(16'h0000, 16'hFFFF);
                push_sample(16'hFFFF, 16'hFFFF);
                push_sample(16'h0001, 16'hFFFF);
                push_sample(16'hFFFF, 16'h0001);
                push_sample(16'h0001, 16'h0001);
                push_sample(16'hFFFF, 16'h8000);
                push_sample(16'h5555, 16'hAAAA);
                push_sample(16'hAAAA, 16'h5555);
            end
            // zero vector lands the heading on the declination itself
            push_sample(16'h0000, 16'h0000);
            for (int k = 0; k < BEATS_PER_SET; k++) begin
                if ($urandom_range(19) == 0) begin
                    push_sample(16'h0000, 16'h0000);
                end else begin
                    push_sample(raw_axis(), raw_axis());
                end
            end
            drain_headings();
        end
        calm = 1'b0;
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        $display("summary: %0d samples in, %0d heading beats checked, %0d errors",
                 n_in, n_out, n_bad);
        $display("summary: %0d declination writes incl. both sign extremes and wrap",
                 n_cfg);
        if (n_bad == 0 && bearing_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/chs_pkg.sv
rtl/chs_cordic_stage.sv
rtl/compass_heading_sector_core.sv
rtl/chs_checker.sv
tb/compass_heading_sector_core_tb.sv
